@@ sv/mfp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mfp_pkg
// Types and constants shared by the track event parser.
// ----------------------------------------------------------------------------
package mfp_pkg;

    typedef enum logic [3:0] {
        PH_DELTA_START = 4'd0,
        PH_DELTA_CONT  = 4'd1,
        PH_STATUS      = 4'd2,
        PH_DATA1       = 4'd3,
        PH_DATA2       = 4'd4,
        PH_SYSEX       = 4'd5,
        PH_META_TYPE   = 4'd6,
        PH_LENGTH      = 4'd7,
        PH_PAYLOAD     = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        KIND_CHANNEL   = 3'd0,
        KIND_SYSEX     = 3'd1,
        KIND_ESCAPE    = 3'd2,
        KIND_META      = 3'd3,
        KIND_UNDEFINED = 3'd4,
        KIND_TRUNCATED = 3'd5,
        KIND_END       = 3'd6
    } t_kind;

    localparam logic [7:0] STAT_CHAN_LO = 8'h80;
    localparam logic [7:0] STAT_SYSEX   = 8'hF0;
    localparam logic [7:0] STAT_ESCAPE  = 8'hF7;
    localparam logic [7:0] STAT_META    = 8'hFF;
    localparam logic [3:0] NIB_PROGRAM  = 4'hC;
    localparam logic [3:0] NIB_PRESSURE = 4'hD;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] delta_time;
        logic [7:0]  status;
        logic [3:0]  channel;
        logic [7:0]  data_first;
        logic [7:0]  data_second;
        logic [7:0]  meta_type;
        logic [31:0] payload_length;
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        last;
    } t_evt;

endpackage
`default_nettype wire

@@ sv/mfp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mfp_if
// Channel interfaces: track bytes in, decoded events out.
// ----------------------------------------------------------------------------
interface mfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface mfp_evt_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] delta_time;
    logic [7:0]  status;
    logic [3:0]  channel;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
    logic [7:0]  meta_type;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        last;

    modport source (
        output valid, output kind, output delta_time, output status, output channel,
        output data_first, output data_second, output meta_type, output payload_length,
        output payload_byte, output payload_valid, output last, input ready
    );
    modport sink (
        input valid, input kind, input delta_time, input status, input channel,
        input data_first, input data_second, input meta_type, input payload_length,
        input payload_byte, input payload_valid, input last, output ready
    );
endinterface
`default_nettype wire

@@ sv/mfp_in_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mfp_in_stage
// Input register for track bytes.
// ----------------------------------------------------------------------------
module mfp_in_stage (
    input  wire               i_clk,
    input  wire               i_rst_n,
    mfp_byte_if.sink          i_trk,
    input  wire               i_take,
    output logic              o_vld,
    output mfp_pkg::t_in      o_in
);
    logic          r_vld;
    mfp_pkg::t_in  r_in;
    logic          w_load;

    assign i_trk.ready = !r_vld || i_take;
    assign w_load      = i_trk.valid && i_trk.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= w_load || (r_vld && !i_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_in.data_byte  <= i_trk.data_byte;
            r_in.stream_end <= i_trk.stream_end;
        end
    end

    assign o_vld = r_vld;
    assign o_in  = r_in;
endmodule
`default_nettype wire

@@ sv/mfp_decode.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mfp_decode
// Parse state and per-byte event decode.
// ----------------------------------------------------------------------------
module mfp_decode (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_go,
    input  wire mfp_pkg::t_in i_in,
    output logic              o_res_vld,
    output mfp_pkg::t_evt     o_res
);
    mfp_pkg::t_phase r_phase, n_phase;
    logic [31:0]     r_delta, n_delta;
    logic [7:0]      r_status, n_status;
    logic [7:0]      r_first, n_first;
    logic [7:0]      r_meta, n_meta;
    logic [31:0]     r_len, n_len;
    logic [31:0]     r_rem, n_rem;
    logic            w_bound;
    mfp_pkg::t_phase w_eff;
    logic [7:0]      w_b;
    logic            w_is_meta;
    mfp_pkg::t_kind  w_long_kind;
    logic [7:0]      w_long_meta;
    logic [31:0]     w_len_next;
    logic [31:0]     w_rem_dec;

    assign w_b = i_in.data_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= mfp_pkg::PH_DELTA_START;
            r_delta  <= '0;
            r_status <= '0;
            r_first  <= '0;
            r_meta   <= '0;
            r_len    <= '0;
            r_rem    <= '0;
        end else if (i_go) begin
            r_phase  <= n_phase;
            r_delta  <= n_delta;
            r_status <= n_status;
            r_first  <= n_first;
            r_meta   <= n_meta;
            r_len    <= n_len;
            r_rem    <= n_rem;
        end
    end

    always_comb begin
        unique case (r_phase)
            mfp_pkg::PH_DELTA_CONT, mfp_pkg::PH_STATUS, mfp_pkg::PH_DATA1,
            mfp_pkg::PH_DATA2, mfp_pkg::PH_SYSEX, mfp_pkg::PH_META_TYPE,
            mfp_pkg::PH_LENGTH, mfp_pkg::PH_PAYLOAD: w_bound = 1'b0;
            default:                                 w_bound = 1'b1;
        endcase
    end

    assign w_eff       = w_bound ? mfp_pkg::PH_DELTA_CONT : r_phase;
    assign w_is_meta   = (r_status == mfp_pkg::STAT_META);
    assign w_long_kind = w_is_meta ? mfp_pkg::KIND_META : mfp_pkg::KIND_ESCAPE;
    assign w_long_meta = w_is_meta ? r_meta : 8'h00;
    assign w_len_next  = {r_len[24:0], w_b[6:0]};
    assign w_rem_dec   = r_rem - 32'd1;

    always_comb begin
        n_phase  = r_phase;
        n_delta  = w_bound ? 32'd0 : r_delta;
        n_status = w_bound ? 8'd0  : r_status;
        n_first  = w_bound ? 8'd0  : r_first;
        n_meta   = w_bound ? 8'd0  : r_meta;
        n_len    = w_bound ? 32'd0 : r_len;
        n_rem    = w_bound ? 32'd0 : r_rem;
        o_res_vld = 1'b0;
        o_res     = '0;
        o_res.last = 1'b1;

        if (i_in.stream_end) begin
            n_delta  = r_delta;
            n_status = r_status;
            n_first  = r_first;
            n_meta   = r_meta;
            n_len    = r_len;
            n_rem    = r_rem;
            o_res_vld = 1'b1;
            if (w_bound) begin
                o_res.kind = mfp_pkg::KIND_END;
            end else begin
                o_res.kind       = mfp_pkg::KIND_TRUNCATED;
                o_res.delta_time = r_delta;
                o_res.status     = r_status;
            end
            n_phase = mfp_pkg::PH_DELTA_START;
        end else begin
            unique case (w_eff)
                mfp_pkg::PH_DELTA_CONT: begin
                    n_delta = {n_delta[24:0], w_b[6:0]};
                    n_phase = w_b[7] ? mfp_pkg::PH_DELTA_CONT : mfp_pkg::PH_STATUS;
                end
                mfp_pkg::PH_STATUS: begin
                    n_status = w_b;
                    if (w_b >= mfp_pkg::STAT_CHAN_LO && w_b < mfp_pkg::STAT_SYSEX) begin
                        n_phase = mfp_pkg::PH_DATA1;
                    end else if (w_b == mfp_pkg::STAT_SYSEX) begin
                        n_phase = mfp_pkg::PH_SYSEX;
                    end else if (w_b == mfp_pkg::STAT_ESCAPE) begin
                        n_len   = 32'd0;
                        n_phase = mfp_pkg::PH_LENGTH;
                    end else if (w_b == mfp_pkg::STAT_META) begin
                        n_phase = mfp_pkg::PH_META_TYPE;
                    end else begin
                        o_res_vld        = 1'b1;
                        o_res.kind       = mfp_pkg::KIND_UNDEFINED;
                        o_res.delta_time = r_delta;
                        o_res.status     = w_b;
                        n_phase          = mfp_pkg::PH_DELTA_START;
                    end
                end
                mfp_pkg::PH_DATA1: begin
                    n_first = w_b;
                    if (r_status[7:4] == mfp_pkg::NIB_PROGRAM ||
                        r_status[7:4] == mfp_pkg::NIB_PRESSURE) begin
                        o_res_vld        = 1'b1;
                        o_res.kind       = mfp_pkg::KIND_CHANNEL;
                        o_res.delta_time = r_delta;
                        o_res.status     = r_status;
                        o_res.channel    = r_status[3:0];
                        o_res.data_first = w_b;
                        n_phase          = mfp_pkg::PH_DELTA_START;
                    end else begin
                        n_phase = mfp_pkg::PH_DATA2;
                    end
                end
                mfp_pkg::PH_DATA2: begin
                    o_res_vld         = 1'b1;
                    o_res.kind        = mfp_pkg::KIND_CHANNEL;
                    o_res.delta_time  = r_delta;
                    o_res.status      = r_status;
                    o_res.channel     = r_status[3:0];
                    o_res.data_first  = r_first;
                    o_res.data_second = w_b;
                    n_phase           = mfp_pkg::PH_DELTA_START;
                end
                mfp_pkg::PH_SYSEX: begin
                    if (w_b == mfp_pkg::STAT_ESCAPE) begin
                        o_res_vld        = 1'b1;
                        o_res.kind       = mfp_pkg::KIND_SYSEX;
                        o_res.delta_time = r_delta;
                        o_res.status     = r_status;
                        n_phase          = mfp_pkg::PH_DELTA_START;
                    end
                end
                mfp_pkg::PH_META_TYPE: begin
                    n_meta  = w_b;
                    n_len   = 32'd0;
                    n_phase = mfp_pkg::PH_LENGTH;
                end
                mfp_pkg::PH_LENGTH: begin
                    n_len = w_len_next;
                    if (!w_b[7]) begin
                        n_rem = w_len_next;
                        if (w_len_next == 32'd0) begin
                            o_res_vld        = 1'b1;
                            o_res.kind       = w_long_kind;
                            o_res.delta_time = r_delta;
                            o_res.status     = r_status;
                            o_res.meta_type  = w_long_meta;
                            n_phase          = mfp_pkg::PH_DELTA_START;
                        end else begin
                            n_phase = mfp_pkg::PH_PAYLOAD;
                        end
                    end
                end
                mfp_pkg::PH_PAYLOAD: begin
                    n_rem                = w_rem_dec;
                    o_res_vld            = 1'b1;
                    o_res.kind           = w_long_kind;
                    o_res.delta_time     = r_delta;
                    o_res.status         = r_status;
                    o_res.meta_type      = w_long_meta;
                    o_res.payload_length = r_len;
                    o_res.payload_byte   = w_b;
                    o_res.payload_valid  = 1'b1;
                    o_res.last           = (w_rem_dec == 32'd0);
                    if (w_rem_dec == 32'd0) begin
                        n_phase = mfp_pkg::PH_DELTA_START;
                    end
                end
                default: begin
                    n_phase = mfp_pkg::PH_DELTA_START;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

@@ sv/mfp_out_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mfp_out_stage
// Result register driving the event channel.
// ----------------------------------------------------------------------------
module mfp_out_stage (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_load,
    input  wire mfp_pkg::t_evt i_res,
    output logic               o_busy,
    mfp_evt_if.source          o_evt
);
    logic           r_vld;
    mfp_pkg::t_evt  r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_load || (r_vld && !o_evt.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_busy               = r_vld && !o_evt.ready;
    assign o_evt.valid          = r_vld;
    assign o_evt.kind           = 3'(r_res.kind);
    assign o_evt.delta_time     = r_res.delta_time;
    assign o_evt.status         = r_res.status;
    assign o_evt.channel        = r_res.channel;
    assign o_evt.data_first     = r_res.data_first;
    assign o_evt.data_second    = r_res.data_second;
    assign o_evt.meta_type      = r_res.meta_type;
    assign o_evt.payload_length = r_res.payload_length;
    assign o_evt.payload_byte   = r_res.payload_byte;
    assign o_evt.payload_valid  = r_res.payload_valid;
    assign o_evt.last           = r_res.last;
endmodule
`default_nettype wire

@@ sv/midi_file_event_parser_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// midi_file_event_parser_top
// Parses a standard MIDI file track, one byte per transfer, into events.
//
//   channel   modport  direction  payload
//   i_trk     sink     in         data_byte, stream_end
//   o_evt     source   out        kind .. last, one event result per transfer
//
// One byte a cycle sustained while o_evt does not stall; a byte is decoded from the input
// register and its result is offered on o_evt from the result register.
// Reset is synchronous and clears the parse state to the start of a delta time.
// A stall on o_evt holds the result register and the decode; the input register
// still takes a byte if it is empty, then i_trk stalls until the result is taken.
// ----------------------------------------------------------------------------
module midi_file_event_parser_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    mfp_byte_if.sink    i_trk,
    mfp_evt_if.source   o_evt
);
    logic           w_in_vld;
    mfp_pkg::t_in   w_in;
    logic           w_go;
    logic           w_res_vld;
    mfp_pkg::t_evt  w_res;
    logic           w_out_busy;

    assign w_go = w_in_vld && !w_out_busy;

    mfp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_trk   (i_trk),
        .i_take  (w_go),
        .o_vld   (w_in_vld),
        .o_in    (w_in)
    );

    mfp_decode u_dec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (w_go),
        .i_in      (w_in),
        .o_res_vld (w_res_vld),
        .o_res     (w_res)
    );

    mfp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_go && w_res_vld),
        .i_res   (w_res),
        .o_busy  (w_out_busy),
        .o_evt   (o_evt)
    );
endmodule
`default_nettype wire
